// ===== sv/cic_pkg.sv =====
// shared types, codes and rotating-priority helpers for the cascaded
// interrupt controller; used by cic_ctrl and the top level
package cic_pkg;

  typedef enum logic [1:0] {
    OP_SIGNAL = 2'd0,
    OP_WRITE  = 2'd1,
    OP_READ   = 2'd2,
    OP_TICK   = 2'd3
  } cic_op_e;

  // command bytes
  localparam logic [7:0] CMD_READ_IRR  = 8'h0A;
  localparam logic [7:0] CMD_READ_ISR  = 8'h0B;
  localparam logic [7:0] CMD_EOI       = 8'h20;
  localparam logic [7:0] CMD_ROT_EOI   = 8'hA0;
  localparam logic [7:0] CMD_SPEC_EOI  = 8'h60;
  localparam logic [7:0] CMD_SET_PRIO  = 8'hC0;
  localparam logic [7:0] CMD_ROT_SPEC  = 8'hE0;
  localparam logic [7:0] CMD_GRP_MASK  = 8'hF8;

  // read modes of a command port
  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_IRR    = 2'd1;
  localparam logic [1:0] MODE_ISR    = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_AT_MODE     = 3'd0;
  localparam logic [2:0] CFG_IRQ2_CHAIN  = 3'd1;
  localparam logic [2:0] CFG_AT_PRIORITY = 3'd2;
  localparam logic [2:0] CFG_ENABLED     = 3'd3;
  localparam logic [2:0] CFG_PRIM_BASE   = 3'd4;
  localparam logic [2:0] CFG_SEC_BASE    = 3'd5;

  localparam logic [2:0] CASCADE_POS = 3'd2;

  // request from the top level to one controller
  typedef struct packed {
    logic [7:0] set_pend;
    logic       wr_cmd;
    logic       wr_mask;
    logic [7:0] data;
    logic       chain;
  } cic_req_t;

  // scan result and read data from one controller
  typedef struct packed {
    logic       hit_own;
    logic       hit_sub;
    logic [2:0] pos;
    logic [7:0] cmd_rd;
    logic [7:0] mask_rd;
  } cic_rsp_t;

  typedef struct packed {
    logic       hit_own;
    logic       hit_sub;
    logic [2:0] pos;
  } cic_scan_t;

  // rotating-priority scan starting one place after lowest priority
  function automatic cic_scan_t scan_prio(logic [7:0] isr, logic [7:0] pend_en,
                                          logic [2:0] lp, logic chain,
                                          logic sub_hit);
    cic_scan_t  r;
    logic [2:0] p;
    logic       done;
    r    = '0;
    p    = lp + 3'd1;
    done = 1'b0;
    for (int k = 0; k < 8; k++) begin
      if (!done) begin
        if (chain && p == CASCADE_POS) begin
          if (sub_hit) begin
            r.hit_sub = 1'b1;
            done      = 1'b1;
          end
        end else if (isr[p]) begin
          done = 1'b1;
        end else if (pend_en[p]) begin
          r.hit_own = 1'b1;
          r.pos     = p;
          done      = 1'b1;
        end
      end
      p = p + 3'd1;
    end
    return r;
  endfunction

  // nonspecific end of interrupt: clear the first in-service bit in order
  function automatic logic [7:0] eoi_clear(logic [7:0] isr, logic [2:0] lp);
    logic [7:0] r;
    logic [2:0] p;
    logic       done;
    r    = isr;
    p    = lp + 3'd1;
    done = 1'b0;
    for (int k = 0; k < 8; k++) begin
      if (!done && isr[p]) begin
        r[p] = 1'b0;
        done = 1'b1;
      end
      p = p + 3'd1;
    end
    return r;
  endfunction

endpackage

// ===== sv/cic_ctrl.sv =====
// one 8259-style controller: pending, in-service and mask state, command
// decode, and its rotating-priority scan; depends on cic_pkg
module cic_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cic_pkg::cic_req_t req_i,
  input  logic              sub_hit_i,
  input  logic              take_i,
  output cic_pkg::cic_rsp_t rsp_o
);

  logic [7:0] pend_q, pend_d;
  logic [7:0] isr_q, isr_d;
  logic [7:0] en_q, en_d;
  logic [2:0] lp_q, lp_d;
  logic       lv_q, lv_d;
  logic [2:0] last_q, last_d;
  logic [7:0] stat_q, stat_d;
  logic [1:0] mode_q, mode_d;

  cic_pkg::cic_scan_t scan;
  logic [7:0]         grp;
  logic [7:0]         low_bit;
  logic [7:0]         take_bit;

  assign scan     = cic_pkg::scan_prio(isr_q, pend_q & en_q, lp_q, req_i.chain,
                                       sub_hit_i);
  assign grp      = req_i.data & cic_pkg::CMD_GRP_MASK;
  assign low_bit  = 8'd1 << req_i.data[2:0];
  assign take_bit = 8'd1 << scan.pos;

  always_comb begin
    pend_d = pend_q | req_i.set_pend;
    isr_d  = isr_q;
    en_d   = en_q;
    lp_d   = lp_q;
    lv_d   = lv_q;
    last_d = last_q;
    stat_d = stat_q;
    mode_d = mode_q;
    if (req_i.wr_mask) begin
      en_d = ~req_i.data;
    end
    if (req_i.wr_cmd) begin
      mode_d = cic_pkg::MODE_NORMAL;
      if (req_i.data == cic_pkg::CMD_READ_IRR) begin
        stat_d = pend_q;
        mode_d = cic_pkg::MODE_IRR;
      end else if (req_i.data == cic_pkg::CMD_READ_ISR) begin
        stat_d = isr_q;
        mode_d = cic_pkg::MODE_ISR;
      end else if (req_i.data == cic_pkg::CMD_EOI) begin
        isr_d = cic_pkg::eoi_clear(isr_q, lp_q);
      end else if (req_i.data == cic_pkg::CMD_ROT_EOI) begin
        if (lv_q) begin
          isr_d = cic_pkg::eoi_clear(isr_q, lp_q);
          lp_d  = last_q;
          lv_d  = 1'b0;
        end
      end else if (grp == cic_pkg::CMD_SPEC_EOI) begin
        isr_d = isr_q & ~low_bit;
      end else if (grp == cic_pkg::CMD_SET_PRIO) begin
        lp_d = req_i.data[2:0];
      end else if (grp == cic_pkg::CMD_ROT_SPEC) begin
        isr_d = isr_q & ~low_bit;
        lp_d  = req_i.data[2:0];
      end
    end
    if (take_i) begin
      isr_d  = isr_q | take_bit;
      pend_d = pend_q & ~take_bit;
      last_d = scan.pos;
      lv_d   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      isr_q  <= '0;
      en_q   <= 8'hFF;
      lp_q   <= 3'd7;
      lv_q   <= 1'b0;
      last_q <= '0;
      stat_q <= '0;
      mode_q <= cic_pkg::MODE_NORMAL;
    end else begin
      pend_q <= pend_d;
      isr_q  <= isr_d;
      en_q   <= en_d;
      lp_q   <= lp_d;
      lv_q   <= lv_d;
      last_q <= last_d;
      stat_q <= stat_d;
      mode_q <= mode_d;
    end
  end

  always_comb begin
    rsp_o.hit_own = scan.hit_own;
    rsp_o.hit_sub = scan.hit_sub;
    rsp_o.pos     = scan.pos;
    rsp_o.mask_rd = ~en_q;
    case (mode_q)
      cic_pkg::MODE_NORMAL: rsp_o.cmd_rd = stat_q;
      cic_pkg::MODE_IRR:    rsp_o.cmd_rd = pend_q;
      cic_pkg::MODE_ISR:    rsp_o.cmd_rd = isr_q;
      default:              rsp_o.cmd_rd = '0;
    endcase
  end

endmodule

// ===== sv/cascaded_interrupt_controller_unit.sv =====
// top level of the cascaded primary/secondary interrupt controller pair
// with config registers and output skid stage; depends on cic_pkg, cic_ctrl
//
// usage: each word on the slave stream is one operation (signal an irq,
// port write, port read or cpu tick), selected by s_axis_tuser. every word
// gives exactly one result word on the master stream: read data for port
// reads, and interrupt_taken with the vector for ticks.
// state updates and the result are computed in the cycle a word is
// accepted; the result is registered into the output or skid register.
// throughput is one word per cycle while s_axis_tready is high; the
// rotating-priority scan of both controllers is combinational.
// the output has a main register and a skid register: a word is still
// accepted while one result waits, and s_axis_tready falls only once both
// hold a result the receiver has not taken.
// the config channel is always ready; write it only while the block idles.
// reset (rst_ni low, asynchronous) restores the config defaults (at mode,
// chain, at priority, enabled, bases 8 and 112), clears pending and
// in-service bits, enables all lines and empties the output stage.
module cascaded_interrupt_controller_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // irq_number[3:0], write_data[11:4],
                                     // cpu_can_interrupt[12], zero[15:13]
  input  logic [3:0]  s_axis_tuser,  // operation[1:0], port_select[3:2]
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // read_data[7:0], interrupt_vector[15:8]
  output logic        m_axis_tuser   // interrupt_taken[0]
);

  typedef struct packed {
    logic [7:0] read_data;
    logic       interrupt_taken;
    logic [7:0] interrupt_vector;
  } res_t;

  logic       at_mode_q, chain_q, at_prio_q, enabled_q;
  logic [7:0] pbase_q, sbase_q;

  cic_pkg::cic_op_e  op;
  logic [3:0]        irq_number;
  logic [7:0]        write_data;
  logic              can_int;
  logic [1:0]        port_sel;
  logic              acc;
  logic              sec;
  logic              port_ok;
  logic [3:0]        irq_eff;
  logic              irq_keep;
  logic              tick_ok;
  logic              prim_take, sec_take;

  cic_pkg::cic_req_t preq, sreq;
  cic_pkg::cic_rsp_t prsp, srsp;

  res_t res;
  res_t out_q, skid_q;
  logic out_v_q, skid_v_q;
  logic take;

  assign op         = cic_pkg::cic_op_e'(s_axis_tuser[1:0]);
  assign port_sel   = s_axis_tuser[3:2];
  assign irq_number = s_axis_tdata[3:0];
  assign write_data = s_axis_tdata[11:4];
  assign can_int    = s_axis_tdata[12];

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !skid_v_q;
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign take          = out_v_q && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_mode_q <= 1'b1;
      chain_q   <= 1'b1;
      at_prio_q <= 1'b1;
      enabled_q <= 1'b1;
      pbase_q   <= 8'd8;
      sbase_q   <= 8'd112;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        cic_pkg::CFG_AT_MODE:     at_mode_q <= cfg_data_i[0];
        cic_pkg::CFG_IRQ2_CHAIN:  chain_q   <= cfg_data_i[0];
        cic_pkg::CFG_AT_PRIORITY: at_prio_q <= cfg_data_i[0];
        cic_pkg::CFG_ENABLED:     enabled_q <= cfg_data_i[0];
        cic_pkg::CFG_PRIM_BASE:   pbase_q   <= cfg_data_i;
        cic_pkg::CFG_SEC_BASE:    sbase_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // irq2 lands on irq9 in at mode with chain set; xt mode drops the secondary lines
  always_comb begin
    irq_eff  = irq_number;
    irq_keep = 1'b1;
    if (at_mode_q) begin
      if (chain_q && irq_number == 4'd2) begin
        irq_eff = 4'd9;
      end
    end else if (irq_number[3]) begin
      irq_keep = 1'b0;
    end
  end

  assign sec     = port_sel[1];
  assign port_ok = !sec || at_mode_q;
  assign tick_ok = acc && op == cic_pkg::OP_TICK && enabled_q && can_int;

  // primary own hit wins; else the secondary, through the cascade or after
  assign prim_take = tick_ok && prsp.hit_own;
  assign sec_take  = tick_ok && at_mode_q && srsp.hit_own && !prsp.hit_own;

  always_comb begin
    preq          = '0;
    sreq          = '0;
    if (acc && op == cic_pkg::OP_SIGNAL && irq_keep) begin
      if (irq_eff[3]) begin
        sreq.set_pend = 8'd1 << irq_eff[2:0];
      end else begin
        preq.set_pend = 8'd1 << irq_eff[2:0];
      end
    end
    preq.data     = write_data;
    sreq.data     = write_data;
    if (acc && op == cic_pkg::OP_WRITE && port_ok) begin
      if (sec) begin
        sreq.wr_cmd  = !port_sel[0];
        sreq.wr_mask = port_sel[0];
      end else begin
        preq.wr_cmd  = !port_sel[0];
        preq.wr_mask = port_sel[0];
      end
    end
    preq.chain    = at_mode_q && at_prio_q;
  end

  cic_ctrl u_prim (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (preq),
    .sub_hit_i (srsp.hit_own),
    .take_i    (prim_take),
    .rsp_o     (prsp)
  );

  cic_ctrl u_sec (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (sreq),
    .sub_hit_i (1'b0),
    .take_i    (sec_take),
    .rsp_o     (srsp)
  );

  always_comb begin
    res = '0;
    if (op == cic_pkg::OP_READ && port_ok) begin
      if (sec) begin
        res.read_data = port_sel[0] ? srsp.mask_rd : srsp.cmd_rd;
      end else begin
        res.read_data = port_sel[0] ? prsp.mask_rd : prsp.cmd_rd;
      end
    end
    if (prim_take) begin
      res.interrupt_taken  = 1'b1;
      res.interrupt_vector = pbase_q + {5'd0, prsp.pos};
    end else if (sec_take) begin
      res.interrupt_taken  = 1'b1;
      res.interrupt_vector = sbase_q + {5'd0, srsp.pos};
    end
  end

  // output register plus skid word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (take) begin
      if (skid_v_q) begin
        skid_v_q <= 1'b0;
      end else if (!acc) begin
        out_v_q <= 1'b0;
      end
    end else if (acc) begin
      if (out_v_q) begin
        skid_v_q <= 1'b1;
      end else begin
        out_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      if (skid_v_q) begin
        out_q <= skid_q;
      end else if (acc) begin
        out_q <= res;
      end
    end else if (acc) begin
      if (out_v_q) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {out_q.interrupt_vector, out_q.read_data};
  assign m_axis_tuser  = out_q.interrupt_taken;

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for cascaded_interrupt_controller_unit: a predictor of the
// primary/secondary controller pair checks every result word in order
// depends on cic_pkg and the rtl of the top level
`timescale 1ns / 100ps

module tb_top;

  localparam int         QUIET_LIMIT   = 2000;
  localparam int         MAX_SHOWN     = 10;
  localparam logic [1:0] PORT_PRI_CMD  = 2'd0;
  localparam logic [1:0] PORT_PRI_MASK = 2'd1;
  localparam logic [1:0] PORT_SEC_CMD  = 2'd2;
  localparam logic [1:0] PORT_SEC_MASK = 2'd3;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [7:0]  cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;  // irq_number[3:0], write_data[11:4], cpu_can_interrupt[12]
  logic [3:0]  s_axis_tuser;  // operation[1:0], port_select[3:2]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;  // read_data[7:0], interrupt_vector[15:8]
  logic        m_axis_tuser;  // interrupt_taken[0]

  cascaded_interrupt_controller_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  typedef struct packed {
    logic [7:0] read_data;
    logic       taken;
    logic [7:0] vector;
  } pic_result_t;

  pic_result_t expected_results[$];

  int send_idle_pct;
  int recv_stall_pct;
  int hold_request;
  int hold_left;
  int items_sent;
  int fail_count;
  int quiet_cycles;

  // predictor copy of the config and of both controllers
  logic       cfg_at, cfg_chain, cfg_atprio, cfg_en;
  logic [7:0] cfg_pbase, cfg_sbase;
  logic [7:0] irr_q[2];
  logic [7:0] isr_q[2];
  logic [7:0] ien_q[2];
  logic [2:0] lowprio_q[2];
  logic [2:0] last_irq_q[2];
  logic       last_ok_q[2];
  logic [7:0] status_q[2];
  logic [1:0] rdmode_q[2];

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  task automatic reset_predictor();
    cfg_at     = 1'b1;
    cfg_chain  = 1'b1;
    cfg_atprio = 1'b1;
    cfg_en     = 1'b1;
    cfg_pbase  = 8'd8;
    cfg_sbase  = 8'd112;
    for (int c = 0; c < 2; c++) begin
      irr_q[c]      = 8'h00;
      isr_q[c]      = 8'h00;
      ien_q[c]      = 8'hFF;
      lowprio_q[c]  = 3'd7;
      last_irq_q[c] = 3'd0;
      last_ok_q[c]  = 1'b0;
      status_q[c]   = 8'h00;
      rdmode_q[c]   = cic_pkg::MODE_NORMAL;
    end
  endtask

  // returns the line that wins the scan, 8 for the cascade slot, -1 for none
  function automatic int pick_line(int c, logic chain, int sec_pick);
    logic [2:0] p;
    p = lowprio_q[c] + 3'd1;
    for (int k = 0; k < 8; k++) begin
      if (chain && p == cic_pkg::CASCADE_POS) begin
        if (sec_pick >= 0) return 8;
      end else if (isr_q[c][p]) begin
        return -1;
      end else if (irr_q[c][p] && ien_q[c][p]) begin
        return int'(p);
      end
      p = p + 3'd1;
    end
    return -1;
  endfunction

  task automatic grant_line(input int c, input int pos, output logic [7:0] vec);
    isr_q[c][pos] = 1'b1;
    irr_q[c][pos] = 1'b0;
    last_irq_q[c] = pos[2:0];
    last_ok_q[c]  = 1'b1;
    vec = (c != 0 ? cfg_sbase : cfg_pbase) + pos[7:0];
  endtask

  task automatic clear_first_isr(input int c);
    logic [2:0] p;
    logic       done;
    p    = lowprio_q[c] + 3'd1;
    done = 1'b0;
    for (int k = 0; k < 8; k++) begin
      if (!done && isr_q[c][p]) begin
        isr_q[c][p] = 1'b0;
        done        = 1'b1;
      end
      p = p + 3'd1;
    end
  endtask

  task automatic apply_command(input int c, input logic [7:0] cmd);
    rdmode_q[c] = cic_pkg::MODE_NORMAL;
    if (cmd == cic_pkg::CMD_READ_IRR) begin
      status_q[c] = irr_q[c];
      rdmode_q[c] = cic_pkg::MODE_IRR;
    end else if (cmd == cic_pkg::CMD_READ_ISR) begin
      status_q[c] = isr_q[c];
      rdmode_q[c] = cic_pkg::MODE_ISR;
    end else if (cmd == cic_pkg::CMD_EOI) begin
      clear_first_isr(c);
    end else if (cmd == cic_pkg::CMD_ROT_EOI) begin
      if (last_ok_q[c]) begin
        clear_first_isr(c);
        lowprio_q[c] = last_irq_q[c];
        last_ok_q[c] = 1'b0;
      end
    end else if ((cmd & cic_pkg::CMD_GRP_MASK) == cic_pkg::CMD_SPEC_EOI) begin
      isr_q[c][cmd[2:0]] = 1'b0;
    end else if ((cmd & cic_pkg::CMD_GRP_MASK) == cic_pkg::CMD_SET_PRIO) begin
      lowprio_q[c] = cmd[2:0];
    end else if ((cmd & cic_pkg::CMD_GRP_MASK) == cic_pkg::CMD_ROT_SPEC) begin
      isr_q[c][cmd[2:0]] = 1'b0;
      lowprio_q[c]       = cmd[2:0];
    end
  endtask

  task automatic predict_result(input cic_pkg::cic_op_e op, input logic [3:0] irq,
                                input logic [1:0] port, input logic [7:0] data,
                                input logic can, output pic_result_t r);
    int         c;
    int         n;
    int         sec;
    int         pri;
    logic [7:0] vec;
    c = int'(port[1]);
    n = int'(irq);
    r = '0;
    case (op)
      cic_pkg::OP_SIGNAL: begin
        if (cfg_at) begin
          if (cfg_chain && n == 2) n = 9;
          if (n >= 8) irr_q[1][n-8] = 1'b1;
          else irr_q[0][n] = 1'b1;
        end else if (n < 8) begin
          irr_q[0][n] = 1'b1;
        end
      end
      cic_pkg::OP_WRITE: begin
        if (c == 0 || cfg_at) begin
          if (port[0]) ien_q[c] = ~data;
          else apply_command(c, data);
        end
      end
      cic_pkg::OP_READ: begin
        if (c == 0 || cfg_at) begin
          if (port[0]) r.read_data = ~ien_q[c];
          else if (rdmode_q[c] == cic_pkg::MODE_IRR) r.read_data = irr_q[c];
          else if (rdmode_q[c] == cic_pkg::MODE_ISR) r.read_data = isr_q[c];
          else r.read_data = status_q[c];
        end
      end
      default: begin
        if (cfg_en && can) begin
          sec = cfg_at ? pick_line(1, 1'b0, -1) : -1;
          pri = pick_line(0, cfg_at && cfg_atprio, sec);
          if (pri == 8 || (pri < 0 && sec >= 0)) begin
            grant_line(1, sec, vec);
            r.taken  = 1'b1;
            r.vector = vec;
          end else if (pri >= 0) begin
            grant_line(0, pri, vec);
            r.taken  = 1'b1;
            r.vector = vec;
          end
        end
      end
    endcase
  endtask

  task automatic send_op(input cic_pkg::cic_op_e op, input logic [3:0] irq,
                         input logic [1:0] port, input logic [7:0] data, input logic can);
    pic_result_t r;
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, can, data, irq};
    s_axis_tuser  <= {port, op};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_result(op, irq, port, data, can, r);
    expected_results.push_back(r);
    items_sent++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] index, input logic [7:0] value);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (index)
      cic_pkg::CFG_AT_MODE:     cfg_at     = value[0];
      cic_pkg::CFG_IRQ2_CHAIN:  cfg_chain  = value[0];
      cic_pkg::CFG_AT_PRIORITY: cfg_atprio = value[0];
      cic_pkg::CFG_ENABLED:     cfg_en     = value[0];
      cic_pkg::CFG_PRIM_BASE:   cfg_pbase  = value;
      cic_pkg::CFG_SEC_BASE:    cfg_sbase  = value;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic at, input logic chain, input logic atprio,
                            input logic en, input logic [7:0] pbase, input logic [7:0] sbase);
    write_reg(cic_pkg::CFG_AT_MODE, {7'd0, at});
    write_reg(cic_pkg::CFG_IRQ2_CHAIN, {7'd0, chain});
    write_reg(cic_pkg::CFG_AT_PRIORITY, {7'd0, atprio});
    write_reg(cic_pkg::CFG_ENABLED, {7'd0, en});
    write_reg(cic_pkg::CFG_PRIM_BASE, pbase);
    write_reg(cic_pkg::CFG_SEC_BASE, sbase);
  endtask

  function automatic logic [7:0] rand_cmd();
    logic [2:0] lo;
    lo = 3'($urandom_range(7));
    case ($urandom_range(7))
      0:       return cic_pkg::CMD_READ_IRR;
      1:       return cic_pkg::CMD_READ_ISR;
      2:       return cic_pkg::CMD_EOI;
      3:       return cic_pkg::CMD_ROT_EOI;
      4:       return cic_pkg::CMD_SPEC_EOI | {5'd0, lo};
      5:       return cic_pkg::CMD_SET_PRIO | {5'd0, lo};
      6:       return cic_pkg::CMD_ROT_SPEC | {5'd0, lo};
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [7:0] rand_eoi();
    logic [2:0] lo;
    lo = 3'($urandom_range(7));
    case ($urandom_range(3))
      0:       return cic_pkg::CMD_EOI;
      1:       return cic_pkg::CMD_ROT_EOI;
      2:       return cic_pkg::CMD_SPEC_EOI | {5'd0, lo};
      default: return cic_pkg::CMD_ROT_SPEC | {5'd0, lo};
    endcase
  endfunction

  task automatic send_random_item();
    cic_pkg::cic_op_e op;
    logic [1:0]       port;
    logic [7:0]       data;
    op   = cic_pkg::cic_op_e'($urandom_range(3));
    port = 2'($urandom_range(3));
    data = 8'($urandom_range(255));
    // mostly light masking and meaningful commands so dispatch keeps going
    if (op == cic_pkg::OP_WRITE && port[0] && $urandom_range(3) != 0)
      data = data & 8'($urandom_range(255)) & 8'($urandom_range(255));
    else if (op == cic_pkg::OP_WRITE && !port[0])
      data = rand_cmd();
    send_op(op, 4'($urandom_range(15)), port, data, 1'($urandom_range(1)));
  endtask

  // raise lines, let the cpu take them, then end the interrupt
  task automatic send_irq_round();
    logic [1:0] port;
    repeat ($urandom_range(1, 3))
      send_op(cic_pkg::OP_SIGNAL, 4'($urandom_range(15)), 2'($urandom_range(3)),
              8'($urandom_range(255)), 1'($urandom_range(1)));
    repeat ($urandom_range(1, 2))
      send_op(cic_pkg::OP_TICK, 4'($urandom_range(15)), 2'($urandom_range(3)),
              8'($urandom_range(255)), $urandom_range(9) != 0);
    port = $urandom_range(1) ? PORT_SEC_CMD : PORT_PRI_CMD;
    if ($urandom_range(4) == 0) begin
      send_op(cic_pkg::OP_WRITE, 4'($urandom_range(15)), port,
              $urandom_range(1) ? cic_pkg::CMD_READ_IRR : cic_pkg::CMD_READ_ISR,
              1'($urandom_range(1)));
      send_op(cic_pkg::OP_READ, 4'($urandom_range(15)), port, 8'($urandom_range(255)),
              1'($urandom_range(1)));
    end
    send_op(cic_pkg::OP_WRITE, 4'($urandom_range(15)), port, rand_eoi(),
            1'($urandom_range(1)));
  endtask

  task automatic run_random(input int count);
    int start;
    start = items_sent;
    while (items_sent - start < count) begin
      if ($urandom_range(99) < 65) send_irq_round();
      else send_random_item();
    end
  endtask

  task automatic test_reset_state();
    send_op(cic_pkg::OP_READ, 4'd0, PORT_PRI_MASK, 8'h00, 1'b0);
    send_op(cic_pkg::OP_READ, 4'd0, PORT_SEC_CMD, 8'h00, 1'b0);
  endtask

  task automatic test_directed_ops();
    send_op(cic_pkg::OP_SIGNAL, 4'd0, PORT_PRI_CMD, 8'h00, 1'b0);
    send_op(cic_pkg::OP_SIGNAL, 4'd15, PORT_SEC_MASK, 8'hFF, 1'b1);
    send_op(cic_pkg::OP_SIGNAL, 4'd2, PORT_PRI_CMD, 8'h00, 1'b0);  // taken as irq9
    send_op(cic_pkg::OP_TICK, 4'd0, PORT_PRI_CMD, 8'h00, 1'b0);    // cpu refuses
    send_op(cic_pkg::OP_WRITE, 4'd0, PORT_PRI_CMD, cic_pkg::CMD_READ_IRR, 1'b0);
    send_op(cic_pkg::OP_READ, 4'd0, PORT_PRI_CMD, 8'h00, 1'b0);
    send_op(cic_pkg::OP_TICK, 4'd0, PORT_PRI_CMD, 8'h00, 1'b1);
    send_op(cic_pkg::OP_WRITE, 4'd0, PORT_SEC_CMD, cic_pkg::CMD_READ_ISR, 1'b0);
    send_op(cic_pkg::OP_READ, 4'd0, PORT_SEC_CMD, 8'h00, 1'b0);
    send_op(cic_pkg::OP_TICK, 4'd15, PORT_SEC_MASK, 8'hFF, 1'b1);
    send_op(cic_pkg::OP_WRITE, 4'd0, PORT_PRI_CMD, cic_pkg::CMD_EOI, 1'b0);
    send_op(cic_pkg::OP_WRITE, 4'd0, PORT_SEC_CMD, cic_pkg::CMD_ROT_EOI, 1'b0);
    // nothing to rotate
    send_op(cic_pkg::OP_WRITE, 4'd0, PORT_SEC_CMD, cic_pkg::CMD_ROT_EOI, 1'b0);
    send_op(cic_pkg::OP_WRITE, 4'd0, PORT_PRI_MASK, 8'hFF, 1'b0);
    send_op(cic_pkg::OP_READ, 4'd0, PORT_PRI_MASK, 8'h00, 1'b0);
    send_op(cic_pkg::OP_TICK, 4'd0, PORT_PRI_CMD, 8'h00, 1'b1);
    send_op(cic_pkg::OP_WRITE, 4'd0, PORT_PRI_MASK, 8'h00, 1'b0);
    send_op(cic_pkg::OP_WRITE, 4'd0, PORT_PRI_CMD, cic_pkg::CMD_SPEC_EOI | 8'h03, 1'b0);
    send_op(cic_pkg::OP_WRITE, 4'd0, PORT_PRI_CMD, cic_pkg::CMD_SET_PRIO | 8'h07, 1'b0);
    send_op(cic_pkg::OP_WRITE, 4'd0, PORT_SEC_CMD, cic_pkg::CMD_ROT_SPEC | 8'h07, 1'b0);
    send_op(cic_pkg::OP_WRITE, 4'd0, PORT_PRI_CMD, 8'hFF, 1'b0);  // unknown command
    send_op(cic_pkg::OP_READ, 4'd0, PORT_PRI_CMD, 8'h00, 1'b0);
    send_op(cic_pkg::OP_WRITE, 4'd0, PORT_SEC_MASK, 8'h55, 1'b0);
    send_op(cic_pkg::OP_READ, 4'd0, PORT_SEC_MASK, 8'h00, 1'b0);
  endtask

  task automatic test_config_modes();
    // xt mode: high lines dropped, secondary ports dead, irq2 stays irq2
    set_config(1'b0, 1'b1, 1'b1, 1'b1, 8'hFF, 8'h00);
    send_op(cic_pkg::OP_SIGNAL, 4'd12, PORT_PRI_CMD, 8'h00, 1'b0);
    send_op(cic_pkg::OP_SIGNAL, 4'd2, PORT_PRI_CMD, 8'h00, 1'b0);
    send_op(cic_pkg::OP_WRITE, 4'd0, PORT_SEC_MASK, 8'hFF, 1'b0);
    send_op(cic_pkg::OP_READ, 4'd0, PORT_SEC_CMD, 8'h00, 1'b0);
    send_op(cic_pkg::OP_TICK, 4'd0, PORT_PRI_CMD, 8'h00, 1'b1);
    send_op(cic_pkg::OP_WRITE, 4'd0, PORT_PRI_CMD, cic_pkg::CMD_EOI, 1'b0);
    // controller off: ticks do nothing
    set_config(1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 8'hFF);
    send_op(cic_pkg::OP_SIGNAL, 4'd2, PORT_PRI_CMD, 8'h00, 1'b0);
    send_op(cic_pkg::OP_SIGNAL, 4'd10, PORT_PRI_CMD, 8'h00, 1'b0);
    send_op(cic_pkg::OP_TICK, 4'd0, PORT_PRI_CMD, 8'h00, 1'b1);
    // no cascade priority: secondary only after primary is idle
    write_reg(cic_pkg::CFG_ENABLED, 8'h01);
    repeat (4) send_op(cic_pkg::OP_TICK, 4'd0, PORT_PRI_CMD, 8'h00, 1'b1);
    send_op(cic_pkg::OP_WRITE, 4'd0, PORT_SEC_CMD, cic_pkg::CMD_EOI, 1'b0);
    send_op(cic_pkg::OP_WRITE, 4'd0, PORT_PRI_CMD, cic_pkg::CMD_ROT_EOI, 1'b0);
  endtask

  task automatic test_random_phases();
    send_idle_pct  = 22;
    recv_stall_pct = 48;
    set_config(1'b1, 1'b1, 1'b1, 1'b1, 8'($urandom_range(255)), 8'($urandom_range(255)));
    run_random(220);
    send_idle_pct  = 48;
    recv_stall_pct = 22;
    set_config(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)), 1'b1,
               8'($urandom_range(255)), 8'($urandom_range(255)));
    run_random(175);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_config(1'b1, 1'($urandom_range(1)), 1'($urandom_range(1)), 1'b1,
               8'($urandom_range(255)), 8'($urandom_range(255)));
    run_random(175);
  endtask

  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    drain_results();
    hold_request = 80;
    repeat (30) send_random_item();
  endtask

  // result stream: drive ready, honoring a long hold when one is requested
  always @(posedge clk_i) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_word
    pic_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_SHOWN)
          $display("unexpected result word: rd %h taken %b vec %h",
                   m_axis_tdata[7:0], m_axis_tuser, m_axis_tdata[15:8]);
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tdata[7:0] !== want.read_data || m_axis_tuser !== want.taken ||
            m_axis_tdata[15:8] !== want.vector) begin
          fail_count++;
          if (fail_count <= MAX_SHOWN)
            $display("mismatch: expected rd %h taken %b vec %h, got rd %h taken %b vec %h",
                     want.read_data, want.taken, want.vector,
                     m_axis_tdata[7:0], m_axis_tuser, m_axis_tdata[15:8]);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin
    rst_ni         <= 1'b0;
    cfg_valid_i    <= 1'b0;
    cfg_index_i    <= '0;
    cfg_data_i     <= '0;
    s_axis_tvalid  <= 1'b0;
    s_axis_tdata   <= '0;
    s_axis_tuser   <= '0;
    m_axis_tready  <= 1'b0;
    send_idle_pct  = 22;
    recv_stall_pct = 48;
    hold_request   = 0;
    hold_left      = 0;
    items_sent     = 0;
    fail_count     = 0;
    quiet_cycles   = 0;
    reset_predictor();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_directed_ops();
    test_config_modes();
    test_random_phases();
    test_backpressure();

    drain_results();
    if (fail_count == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule
